@@ rtl/core/uuid_linear_probe_hash_table_macros.svh @@
// Assertion macros shared by the hash table RTL.
`ifndef UUID_LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define UUID_LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LPHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants of the linear-probing identifier hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned SLOTS        = 1024;
  localparam int unsigned SLOT_W       = $clog2(SLOTS);
  localparam int unsigned CNT_W        = SLOT_W + 1;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned HASH_W       = 32;
  localparam int unsigned SIZE_W       = 11;
  localparam int unsigned FIFO_DEPTH   = 2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [1:0] ADDR_TABLE_SIZE = 2'd0;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_NEXT   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_MATCH    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_END      = 3'd4,
    ST_ZERO     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [1:0] {
    BE_SWEEP,
    BE_IDLE,
    BE_READ,
    BE_EVAL
  } be_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [31:0] payload_in;
    logic [9:0]  prev_slot;
    logic        has_prev;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  slot;
    logic [10:0] probe_count;
    logic [31:0] payload_out;
    logic [63:0] found_key_low;
    logic [63:0] found_key_high;
  } res_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] home;
  } job_t;

endpackage

@@ rtl/core/lpht_ram.sv @@
// ----------------------------------------------------------------------------
// lpht_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/lpht_front.sv @@
// ----------------------------------------------------------------------------
// lpht_front
// Accepts commands and works out the home slot, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lpht_front import lpht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  cmd_t             cmd_i,
  input  logic [CNT_W-1:0] size_i,
  input  logic             hold_i,
  output logic             busy_o,
  input  logic             full_i,
  output logic             push_o,
  output job_t             job_o
);

  fe_state_e         state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [HASH_W-1:0] div_q, div_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [4:0]        bit_q, bit_d;
  logic [CNT_W:0]    trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    div_d   = div_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    push_o  = 1'b0;
    trial   = {rem_q, div_q[HASH_W-1]};
    unique case (state_q)
      FE_IDLE: begin
        if (start_i && !hold_i) begin
          cmd_d   = cmd_i;
          div_d   = cmd_i.key_low[HASH_W-1:0];
          rem_d   = '0;
          bit_d   = '0;
          state_d = FE_DIV;
        end
      end
      FE_DIV: begin
        // restoring step: shift in one dividend bit, subtract if it fits
        if (trial >= {1'b0, size_i}) begin
          rem_d = CNT_W'(trial - {1'b0, size_i});
        end else begin
          rem_d = CNT_W'(trial);
        end
        div_d = {div_q[HASH_W-2:0], 1'b0};
        bit_d = bit_q + 5'd1;
        if (bit_q == 5'(HASH_W - 1)) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  assign busy_o     = (state_q != FE_IDLE) || hold_i;
  assign job_o.cmd  = cmd_q;
  assign job_o.home = SLOT_W'(rem_q);

endmodule

@@ rtl/core/lpht_fifo.sv @@
// ----------------------------------------------------------------------------
// lpht_fifo
// Short job queue between the hashing front and the probing back.
// ----------------------------------------------------------------------------
`include "uuid_linear_probe_hash_table_macros.svh"

module lpht_fifo import lpht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  job_t                 buf_q [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_q, rd_q;
  logic [PTR_W:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= job_i;
    end
  end

  assign job_o   = buf_q[rd_q];
  assign full_o  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);

  `LPHT_ASSERT_IMP(a_no_overflow, push_i, !full_o, "push into a full queue")
  `LPHT_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "pop from an empty queue")

endmodule

@@ rtl/core/lpht_back.sv @@
// ----------------------------------------------------------------------------
// lpht_back
// Probe sequencer: walks the slot memories and issues one result per job.
// ----------------------------------------------------------------------------
`include "uuid_linear_probe_hash_table_macros.svh"

module lpht_back import lpht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] size_i,
  input  job_t             job_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             init_o,
  output logic             done_o,
  output res_t             res_o
);

  be_state_e         state_q, state_d;
  job_t              job_q, job_d;
  logic [SLOT_W-1:0] s_q, s_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [SLOT_W-1:0] sweep_q, sweep_d;
  logic              clr_q, clr_d;
  logic              init_q, init_d;
  logic              done_q, done_d;
  res_t              res_q, res_d;

  logic                    key_we, pay_we;
  logic [SLOT_W-1:0]       addr;
  logic [PAYLOAD_BITS-1:0] pay_wdata, pay_rdata;
  logic [KEY_W-1:0]        klo_rdata, khi_rdata;
  logic [PAYLOAD_BITS-1:0] new_pay;
  logic                    empty_slot, key_hit;
  logic [CNT_W-1:0]        s_inc;
  logic [31:0]             start_pos;

  lpht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_low (
    .clk_i, .we_i(key_we), .addr_i(addr), .wdata_i(job_q.cmd.key_low), .rdata_o(klo_rdata)
  );
  lpht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_high (
    .clk_i, .we_i(key_we), .addr_i(addr), .wdata_i(job_q.cmd.key_high), .rdata_o(khi_rdata)
  );
  lpht_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_payload (
    .clk_i, .we_i(pay_we), .addr_i(addr), .wdata_i(pay_wdata), .rdata_o(pay_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_SWEEP;
      sweep_q <= '0;
      clr_q   <= 1'b0;
      init_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      clr_q   <= clr_d;
      init_q  <= init_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    s_q   <= s_d;
    i_q   <= i_d;
    res_q <= res_d;
  end

  assign new_pay    = PAYLOAD_BITS'(job_q.cmd.payload_in);
  assign empty_slot = (pay_rdata == '0);
  assign key_hit    = (klo_rdata == job_q.cmd.key_low) && (khi_rdata == job_q.cmd.key_high);
  assign s_inc      = CNT_W'(s_q) + 1'b1;
  assign start_pos  = job_i.cmd.has_prev ? 32'(job_i.cmd.prev_slot) + 32'd1 : 32'd0;

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    s_d       = s_q;
    i_d       = i_q;
    sweep_d   = sweep_q;
    clr_d     = clr_q;
    init_d    = init_q;
    done_d    = 1'b0;
    res_d     = '0;
    pop_o     = 1'b0;
    key_we    = 1'b0;
    pay_we    = 1'b0;
    pay_wdata = new_pay;
    addr      = s_q;
    unique case (state_q)
      BE_SWEEP: begin
        addr      = sweep_q;
        pay_we    = 1'b1;
        pay_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == SLOT_W'(SLOTS - 1)) begin
          if (clr_q) begin
            done_d       = 1'b1;
            res_d.status = ST_NEW;
          end
          clr_d   = 1'b0;
          init_d  = 1'b0;
          state_d = BE_IDLE;
        end
      end
      BE_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          s_d   = job_i.home;
          i_d   = '0;
          unique case (job_i.cmd.kind)
            KIND_INSERT: begin
              if (PAYLOAD_BITS'(job_i.cmd.payload_in) == '0) begin
                done_d       = 1'b1;
                res_d.status = ST_ZERO;
              end else begin
                state_d = BE_READ;
              end
            end
            KIND_LOOKUP: state_d = BE_READ;
            KIND_NEXT: begin
              if (start_pos < 32'(size_i)) begin
                s_d     = SLOT_W'(start_pos);
                state_d = BE_READ;
              end else begin
                done_d       = 1'b1;
                res_d.status = ST_END;
              end
            end
            KIND_CLEAR: begin
              sweep_d = '0;
              clr_d   = 1'b1;
              state_d = BE_SWEEP;
            end
            default: state_d = BE_IDLE;
          endcase
        end
      end
      BE_READ: state_d = BE_EVAL;
      BE_EVAL: begin
        // advance to the next slot unless this one decides the job
        state_d = BE_READ;
        i_d     = i_q + 1'b1;
        s_d     = (s_inc == size_i) ? '0 : SLOT_W'(s_inc);
        unique case (job_q.cmd.kind)
          KIND_INSERT: begin
            if (empty_slot || key_hit) begin
              key_we            = 1'b1;
              pay_we            = 1'b1;
              done_d            = 1'b1;
              res_d.status      = empty_slot ? ST_NEW : ST_MATCH;
              res_d.slot        = 10'(s_q);
              res_d.probe_count = 11'(i_q);
              res_d.payload_out = 32'(pay_rdata);
              state_d           = BE_IDLE;
            end else if (i_q + 1'b1 == size_i) begin
              done_d            = 1'b1;
              res_d.status      = ST_FULL;
              res_d.slot        = 10'(job_q.home);
              res_d.probe_count = 11'(size_i);
              state_d           = BE_IDLE;
            end
          end
          KIND_LOOKUP: begin
            if (empty_slot || (i_q + 1'b1 == size_i && !key_hit)) begin
              done_d       = 1'b1;
              res_d.status = ST_NOTFOUND;
              state_d      = BE_IDLE;
            end else if (key_hit) begin
              done_d            = 1'b1;
              res_d.status      = ST_MATCH;
              res_d.slot        = 10'(s_q);
              res_d.payload_out = 32'(pay_rdata);
              state_d           = BE_IDLE;
            end
          end
          KIND_NEXT: begin
            s_d = SLOT_W'(s_inc);
            if (!empty_slot) begin
              done_d               = 1'b1;
              res_d.status         = ST_MATCH;
              res_d.slot           = 10'(s_q);
              res_d.payload_out    = 32'(pay_rdata);
              res_d.found_key_low  = klo_rdata;
              res_d.found_key_high = khi_rdata;
              state_d              = BE_IDLE;
            end else if (s_inc >= size_i) begin
              done_d       = 1'b1;
              res_d.status = ST_END;
              state_d      = BE_IDLE;
            end
          end
          default: state_d = BE_IDLE;
        endcase
      end
      default: state_d = BE_IDLE;
    endcase
  end

  assign init_o = init_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  `LPHT_ASSERT_IMP(a_no_pop_in_sweep, state_q == BE_SWEEP, !pop_o, "job taken during sweep")
  `LPHT_ASSERT_IMP(a_probe_bound, state_q == BE_EVAL, i_q < size_i, "probe count past size")
  `LPHT_ASSERT_IMP(a_slot_bound, state_q == BE_READ, CNT_W'(s_q) < size_i,
                   "probe slot outside table")

endmodule

@@ rtl/core/uuid_linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// uuid_linear_probe_hash_table
// Linear-probing hash table keyed by 128-bit identifiers, with APB sizing.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each command gives
// one result, shown on res_o for a single cycle with done_o high. The front
// computes the home slot with a bit-serial remainder unit, then the probe
// sequencer visits each slot in a read state and an evaluate state, as the
// slot memories have registered reads; the two overlap through a two-entry
// queue. A clear sweeps all 1024 slots, one per cycle, and so does the pass
// after reset, during which busy stays high.
module uuid_linear_probe_hash_table import lpht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        done_o,
  output res_t        res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]  size_eff;
  logic              init;
  logic              push, full, pop, empty;
  job_t              job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_TABLE_SIZE) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  // zero acts as one slot, anything beyond the memory as the full memory
  always_comb begin
    if (size_q == '0) begin
      size_eff = CNT_W'(1);
    end else if (32'(size_q) > 32'(SLOTS)) begin
      size_eff = CNT_W'(SLOTS);
    end else begin
      size_eff = CNT_W'(size_q);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TABLE_SIZE) ? 32'(size_q) : '0;

  lpht_front u_front (
    .clk_i, .rst_ni,
    .start_i(start), .cmd_i, .size_i(size_eff), .hold_i(init), .busy_o(busy),
    .full_i(full), .push_o(push), .job_o(job_in)
  );

  lpht_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .job_i(job_in), .full_o(full),
    .pop_i(pop), .job_o(job_out), .empty_o(empty)
  );

  lpht_back u_back (
    .clk_i, .rst_ni,
    .size_i(size_eff), .job_i(job_out), .empty_i(empty), .pop_o(pop),
    .init_o(init), .done_o, .res_o
  );

endmodule
